// ===== sv/pfch_pkg.sv =====
package pfch_pkg;

  // Field widths
  localparam int ENTRY_W   = 64;
  localparam int FRAME_W   = 55;
  localparam int HASH_W    = 64;
  localparam int FIELD_W   = 32;
  localparam int CODE_W    = 2;
  localparam int PRESENT_B = 63;

  // Configuration port geometry: two registers, read as 64 bits, at byte offsets 0 and 8
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_SEL_B  = 3;
  localparam logic REG_WINDOW_LOW  = 1'b0;
  localparam logic REG_WINDOW_HIGH = 1'b1;

  // Visibility warning codes on the last page of a region
  localparam logic [CODE_W-1:0] VIS_FINE     = 2'd0;
  localparam logic [CODE_W-1:0] VIS_NONE     = 2'd1;
  localparam logic [CODE_W-1:0] VIS_ALL_ZERO = 2'd2;

  // Page item after frame extraction
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               first_page;
    logic               last_page;
  } pfch_item_t;

  // Frame window from the configuration registers
  typedef struct packed {
    logic [FRAME_W-1:0] low;
    logic [FRAME_W-1:0] high;
  } pfch_window_t;

  // One result per page
  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [FIELD_W-1:0] pages_seen;
    logic [FIELD_W-1:0] pages_present;
    logic [FIELD_W-1:0] pages_in_window;
    logic [FRAME_W-1:0] first_frame;
    logic [FRAME_W-1:0] largest_frame;
    logic [HASH_W-1:0]  frame_hash;
    logic               region_done;
    logic [CODE_W-1:0]  visibility_code;
  } pfch_result_t;

  // hash * 1099511628211 + frame mod 2^64.
  // The multiplier is 2^40 + 0x1B3, 0x1B3 = 256 + 128 + 32 + 16 + 2 + 1.
  function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0]  h,
                                                  input logic [FRAME_W-1:0] f);
    logic [HASH_W-1:0] lo_sum;
    logic [HASH_W-1:0] hi_sum;
    lo_sum = (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    hi_sum = (h << 40) + HASH_W'(f);
    return lo_sum + hi_sum;
  endfunction

endpackage

// ===== sv/pfch_if.sv =====
// Page entry channel
interface pfch_in_if;
  logic                            valid;
  logic                            ready;
  logic [pfch_pkg::ENTRY_W-1:0]    entry;
  logic                            read_ok;
  logic                            first_page;
  logic                            last_page;

  modport source (output valid, entry, read_ok, first_page, last_page, input ready);
  modport sink   (input valid, entry, read_ok, first_page, last_page, output ready);
endinterface

// Census result channel
interface pfch_out_if;
  logic                            valid;
  logic                            ready;
  logic [pfch_pkg::FRAME_W-1:0]    frame_number;
  logic [pfch_pkg::FIELD_W-1:0]    pages_seen;
  logic [pfch_pkg::FIELD_W-1:0]    pages_present;
  logic [pfch_pkg::FIELD_W-1:0]    pages_in_window;
  logic [pfch_pkg::FRAME_W-1:0]    first_frame;
  logic [pfch_pkg::FRAME_W-1:0]    largest_frame;
  logic [pfch_pkg::HASH_W-1:0]     frame_hash;
  logic                            region_done;
  logic [pfch_pkg::CODE_W-1:0]     visibility_code;

  modport source (output valid, frame_number, pages_seen, pages_present, pages_in_window,
                  first_frame, largest_frame, frame_hash, region_done, visibility_code,
                  input ready);
  modport sink   (input valid, frame_number, pages_seen, pages_present, pages_in_window,
                  first_frame, largest_frame, frame_hash, region_done, visibility_code,
                  output ready);
endinterface

// ===== sv/pfch_cfg.sv =====
module pfch_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfch_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfch_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfch_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output pfch_pkg::pfch_window_t          window
);

  logic [pfch_pkg::FRAME_W-1:0] win_low_r,  win_low_nxt;
  logic [pfch_pkg::FRAME_W-1:0] win_high_r, win_high_nxt;
  logic                         wr_en;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[pfch_pkg::CFG_SEL_B];

  // Register write on the access phase
  always_comb begin
    win_low_nxt  = win_low_r;
    win_high_nxt = win_high_r;
    if (wr_en) begin
      case (reg_sel)
        pfch_pkg::REG_WINDOW_LOW:  win_low_nxt  = pwdata[pfch_pkg::FRAME_W-1:0];
        pfch_pkg::REG_WINDOW_HIGH: win_high_nxt = pwdata[pfch_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_low_r  <= '0;
      win_high_r <= '0;
    end else begin
      win_low_r  <= win_low_nxt;
      win_high_r <= win_high_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      pfch_pkg::REG_WINDOW_LOW:  prdata = pfch_pkg::CFG_DATA_W'(win_low_r);
      pfch_pkg::REG_WINDOW_HIGH: prdata = pfch_pkg::CFG_DATA_W'(win_high_r);
      default:                   prdata = '0;
    endcase
  end

  assign window.low  = win_low_r;
  assign window.high = win_high_r;

endmodule

// ===== sv/pfch_stats.sv =====
module pfch_stats #(
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  pfch_pkg::pfch_item_t   item,
  input  pfch_pkg::pfch_window_t window,
  output pfch_pkg::pfch_result_t result
);

  logic [COUNT_BITS-1:0]        page_r,   page_nxt;
  logic [COUNT_BITS-1:0]        pres_r,   pres_nxt;
  logic [COUNT_BITS-1:0]        win_r,    win_nxt;
  logic [pfch_pkg::FRAME_W-1:0] first_r,  first_nxt;
  logic [pfch_pkg::FRAME_W-1:0] peak_r,   peak_nxt;
  logic [pfch_pkg::HASH_W-1:0]  hash_r,   hash_nxt;

  logic [COUNT_BITS-1:0]        page_base, pres_base, win_base;
  logic [pfch_pkg::FRAME_W-1:0] first_base, peak_base;
  logic [pfch_pkg::HASH_W-1:0]  hash_base;
  logic                         present;
  logic                         in_window;
  logic [pfch_pkg::CODE_W-1:0]  code;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // First page starts the region from a clean slate
  always_comb begin
    page_base  = item.first_page ? '0 : page_r;
    pres_base  = item.first_page ? '0 : pres_r;
    win_base   = item.first_page ? '0 : win_r;
    first_base = item.first_page ? '0 : first_r;
    peak_base  = item.first_page ? '0 : peak_r;
    hash_base  = item.first_page ? '0 : hash_r;
  end

  assign present   = (item.frame != '0);
  assign in_window = present && (window.high != '0) &&
                     (item.frame >= window.low) && (item.frame < window.high);

  // Census update for this page
  always_comb begin
    page_nxt  = sat_inc(page_base);
    pres_nxt  = present ? sat_inc(pres_base) : pres_base;
    win_nxt   = in_window ? sat_inc(win_base) : win_base;
    first_nxt = (present && (pres_base == '0)) ? item.frame : first_base;
    peak_nxt  = (present && (item.frame > peak_base)) ? item.frame : peak_base;
    hash_nxt  = present ? pfch_pkg::hash_step(hash_base, item.frame) : hash_base;
  end

  // Visibility warning, only on the last page
  always_comb begin
    code = pfch_pkg::VIS_FINE;
    if (item.last_page) begin
      if ((page_nxt != '0) && (pres_nxt == '0)) begin
        code = pfch_pkg::VIS_NONE;
      end else if ((pres_nxt != '0) && (peak_nxt == '0)) begin
        code = pfch_pkg::VIS_ALL_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r  <= '0;
      pres_r  <= '0;
      win_r   <= '0;
      first_r <= '0;
      peak_r  <= '0;
      hash_r  <= '0;
    end else if (advance) begin
      page_r  <= page_nxt;
      pres_r  <= pres_nxt;
      win_r   <= win_nxt;
      first_r <= first_nxt;
      peak_r  <= peak_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // Result fields carry the low bits of the counters
  always_comb begin
    result.frame_number    = item.frame;
    result.pages_seen      = pfch_pkg::FIELD_W'(page_nxt);
    result.pages_present   = pfch_pkg::FIELD_W'(pres_nxt);
    result.pages_in_window = pfch_pkg::FIELD_W'(win_nxt);
    result.first_frame     = first_nxt;
    result.largest_frame   = peak_nxt;
    result.frame_hash      = hash_nxt;
    result.region_done     = item.last_page;
    result.visibility_code = code;
  end

endmodule

// ===== sv/page_frame_census_hash_unit.sv =====
// Channel   Dir  Transfer when          Carries
// in_ch     in   valid & ready          entry, read_ok, first_page, last_page
// out_ch    out  valid & ready          frame, counts, first/largest frame, hash, code
// cfg (APB) in   psel&penable&pwrite    window_low @0x0, window_high @0x8
//
// One page per cycle sustained while out_ch accepts. An accepted entry sits in the input
// register while the census update and the hash's shift-add multiply are computed from
// it, and the result is then registered in the output register and offered from there.
// A stall on out_ch holds both stages and deasserts in_ch.ready only when both are full.
// rst_n is synchronous and clears the census, the window registers and all valid flags.
module page_frame_census_hash_unit #(
  parameter int COUNT_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  pfch_in_if.sink                         in_ch,
  pfch_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfch_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfch_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfch_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  pfch_pkg::pfch_window_t window;
  pfch_pkg::pfch_item_t   item_r, item_nxt;
  pfch_pkg::pfch_result_t res_comb;
  pfch_pkg::pfch_result_t res_r;
  logic                   item_vld_r;
  logic                   out_vld_r;
  logic                   out_free;
  logic                   advance;
  logic                   in_xfer;

  pfch_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  // Handshake: each stage moves when the one after it has room
  assign out_free    = !out_vld_r || out_ch.ready;
  assign advance     = item_vld_r && out_free;
  assign in_ch.ready = !item_vld_r || out_free;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Frame extraction at the input register
  always_comb begin
    item_nxt.frame      = (in_ch.read_ok && in_ch.entry[pfch_pkg::PRESENT_B]) ?
                          in_ch.entry[pfch_pkg::FRAME_W-1:0] : '0;
    item_nxt.first_page = in_ch.first_page;
    item_nxt.last_page  = in_ch.last_page;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
  end

  pfch_stats #(
    .COUNT_BITS (COUNT_BITS)
  ) u_stats (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .window  (window),
    .result  (res_comb)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_comb;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.frame_number    = res_r.frame_number;
  assign out_ch.pages_seen      = res_r.pages_seen;
  assign out_ch.pages_present   = res_r.pages_present;
  assign out_ch.pages_in_window = res_r.pages_in_window;
  assign out_ch.first_frame     = res_r.first_frame;
  assign out_ch.largest_frame   = res_r.largest_frame;
  assign out_ch.frame_hash      = res_r.frame_hash;
  assign out_ch.region_done     = res_r.region_done;
  assign out_ch.visibility_code = res_r.visibility_code;

  // An accepted entry always lands in the input register
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> item_vld_r)
    else $error("accepted entry not held in input register");

  // A present frame can never exceed the running maximum, and the first frame is then nonzero
  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.frame_number != '0) |->
      (res_r.largest_frame >= res_r.frame_number) && (res_r.first_frame != '0))
    else $error("largest or first frame inconsistent with present page");

  // Warning code only on the last page of a region
  a_code_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.region_done |-> (res_r.visibility_code == pfch_pkg::VIS_FINE))
    else $error("visibility code outside last page");

  // A present page cannot report an empty region
  a_code_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.frame_number != '0) |->
      (res_r.visibility_code != pfch_pkg::VIS_NONE))
    else $error("no-present code on a present page");

endmodule

// ===== verif/tb_page_frame_census_hash_unit.sv =====
`timescale 1ns / 1ps

module tb_page_frame_census_hash_unit;

  localparam int ENTRY_W    = pfch_pkg::ENTRY_W;
  localparam int FRAME_W    = pfch_pkg::FRAME_W;
  localparam int HASH_W     = pfch_pkg::HASH_W;
  localparam int FIELD_W    = pfch_pkg::FIELD_W;
  localparam int CODE_W     = pfch_pkg::CODE_W;
  localparam int PRESENT_B  = pfch_pkg::PRESENT_B;
  localparam int CFG_ADDR_W = pfch_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = pfch_pkg::CFG_DATA_W;
  localparam int CFG_SEL_B  = pfch_pkg::CFG_SEL_B;

  localparam logic [FRAME_W-1:0] FRAME_MAX    = {FRAME_W{1'b1}};
  localparam logic [ENTRY_W-1:0] PRESENT_MASK = ENTRY_W'(1) << PRESENT_B;
  localparam logic [HASH_W-1:0]  HASH_PRIME   = 64'd1099511628211;
  localparam int PHASE_ITEMS   = 230;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 60;

  typedef enum int {SRC_LIGHT_RX_HEAVY, SRC_HEAVY_RX_LIGHT, NO_IDLE} idle_mode_t;

  // one row of the directed table: either a register write or a page
  typedef struct {
    bit                     is_cfg;
    logic                   reg_sel;
    logic [CFG_DATA_W-1:0]  value;
    logic [ENTRY_W-1:0]     entry;
    logic                   read_ok;
    logic                   first_pg;
    logic                   last_pg;
    bit                     typed;
    pfch_pkg::pfch_result_t want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  pfch_in_if  in_ch();
  pfch_out_if out_ch();

  page_frame_census_hash_unit #(.COUNT_BITS(32)) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // census mirror: region counters, frames, hash and the window registers
  logic [FIELD_W-1:0] seen_cnt, present_cnt, window_cnt;
  logic [FRAME_W-1:0] first_seen, peak_seen;
  logic [HASH_W-1:0]  hash_acc;
  logic [FRAME_W-1:0] win_lo, win_hi;

  pfch_pkg::pfch_result_t census_expected[$];
  pfch_pkg::pfch_result_t census_got;
  stim_row_t              directed_rows[$];
  int                     mismatch_count = 0;
  int                     src_idle_pct;
  int                     rx_idle_pct;
  int                     hold_left = 0;
  int                     hold_req = 0;
  int                     hold_taken = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [FIELD_W-1:0] sat_bump(input logic [FIELD_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // advance the census by one page and return the result it should produce
  function automatic pfch_pkg::pfch_result_t census_step(input logic [ENTRY_W-1:0] entry,
                                                         input logic read_ok, first_pg,
                                                         last_pg);
    pfch_pkg::pfch_result_t r;
    logic [FRAME_W-1:0]     frame;
    if (first_pg) begin
      seen_cnt    = '0;
      present_cnt = '0;
      window_cnt  = '0;
      first_seen  = '0;
      peak_seen   = '0;
      hash_acc    = '0;
    end
    frame    = (read_ok && entry[PRESENT_B]) ? entry[FRAME_W-1:0] : '0;
    seen_cnt = sat_bump(seen_cnt);
    if (frame != '0) begin
      if (present_cnt == '0) first_seen = frame;
      present_cnt = sat_bump(present_cnt);
      if (frame > peak_seen) peak_seen = frame;
      hash_acc = hash_acc * HASH_PRIME + HASH_W'(frame);
      if (win_hi != '0 && frame >= win_lo && frame < win_hi) window_cnt = sat_bump(window_cnt);
    end
    r.frame_number    = frame;
    r.pages_seen      = seen_cnt;
    r.pages_present   = present_cnt;
    r.pages_in_window = window_cnt;
    r.first_frame     = first_seen;
    r.largest_frame   = peak_seen;
    r.frame_hash      = hash_acc;
    r.region_done     = last_pg;
    r.visibility_code = pfch_pkg::VIS_FINE;
    if (last_pg) begin
      if (seen_cnt != '0 && present_cnt == '0) r.visibility_code = pfch_pkg::VIS_NONE;
      else if (present_cnt != '0 && peak_seen == '0) r.visibility_code = pfch_pkg::VIS_ALL_ZERO;
    end
    return r;
  endfunction

  function automatic pfch_pkg::pfch_result_t census_row(input logic [FRAME_W-1:0] frame,
                                                        input logic [FIELD_W-1:0] seen, present,
                                                        in_win,
                                                        input logic [FRAME_W-1:0] first_f,
                                                        largest,
                                                        input logic [HASH_W-1:0]  hash,
                                                        input logic done,
                                                        input logic [CODE_W-1:0] code);
    pfch_pkg::pfch_result_t r;
    r = {frame, seen, present, in_win, first_f, largest, hash, done, code};
    return r;
  endfunction

  // random entry, frame aimed at the window edges, the extremes, zero or inside the window, or fully random
  function automatic logic [ENTRY_W-1:0] pick_entry();
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] span;
    logic [7:0]         junk;
    junk = 8'($urandom);
    case ($urandom_range(9))
      0: frame = FRAME_W'({$urandom, $urandom});
      1: frame = win_lo + FRAME_W'($urandom_range(2)) - 1'b1;
      2: frame = win_hi + FRAME_W'($urandom_range(2)) - 2'd2;
      3: frame = FRAME_MAX - FRAME_W'($urandom_range(3));
      4: frame = '0;
      default: begin
        span = win_hi - win_lo;
        if (win_hi > win_lo) frame = win_lo + FRAME_W'({$urandom, $urandom}) % span;
        else frame = FRAME_W'($urandom_range(1, 64));
      end
    endcase
    return {($urandom_range(9) != 0), junk, frame};
  endfunction

  task automatic add_cfg(input logic sel, input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.value   = value;
    directed_rows.push_back(row);
  endtask

  task automatic add_page(input logic [ENTRY_W-1:0] entry, input logic read_ok,
                          input logic first_pg, last_pg);
    stim_row_t row;
    row = '{default: '0};
    row.entry    = entry;
    row.read_ok  = read_ok;
    row.first_pg = first_pg;
    row.last_pg  = last_pg;
    directed_rows.push_back(row);
  endtask

  task automatic add_checked_page(input logic [ENTRY_W-1:0] entry, input logic read_ok,
                                  input logic first_pg, last_pg,
                                  input pfch_pkg::pfch_result_t want);
    stim_row_t row;
    row = '{default: '0};
    row.entry    = entry;
    row.read_ok  = read_ok;
    row.first_pg = first_pg;
    row.last_pg  = last_pg;
    row.typed    = 1'b1;
    row.want     = want;
    directed_rows.push_back(row);
  endtask

  task automatic note_mismatch(input string what, input logic [HASH_W-1:0] got, want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input pfch_pkg::pfch_result_t got, want);
    if (got.frame_number !== want.frame_number)
      note_mismatch("frame_number", HASH_W'(got.frame_number), HASH_W'(want.frame_number));
    if (got.pages_seen !== want.pages_seen)
      note_mismatch("pages_seen", HASH_W'(got.pages_seen), HASH_W'(want.pages_seen));
    if (got.pages_present !== want.pages_present)
      note_mismatch("pages_present", HASH_W'(got.pages_present),
                    HASH_W'(want.pages_present));
    if (got.pages_in_window !== want.pages_in_window)
      note_mismatch("pages_in_window", HASH_W'(got.pages_in_window),
                    HASH_W'(want.pages_in_window));
    if (got.first_frame !== want.first_frame)
      note_mismatch("first_frame", HASH_W'(got.first_frame), HASH_W'(want.first_frame));
    if (got.largest_frame !== want.largest_frame)
      note_mismatch("largest_frame", HASH_W'(got.largest_frame), HASH_W'(want.largest_frame));
    if (got.frame_hash !== want.frame_hash)
      note_mismatch("frame_hash", got.frame_hash, want.frame_hash);
    if (got.region_done !== want.region_done)
      note_mismatch("region_done", HASH_W'(got.region_done), HASH_W'(want.region_done));
    if (got.visibility_code !== want.visibility_code)
      note_mismatch("visibility_code", HASH_W'(got.visibility_code),
                    HASH_W'(want.visibility_code));
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      SRC_LIGHT_RX_HEAVY: begin
        src_idle_pct = 17;
        rx_idle_pct  = 62;
      end
      SRC_HEAVY_RX_LIGHT: begin
        src_idle_pct = 62;
        rx_idle_pct  = 17;
      end
      default: begin
        src_idle_pct = 0;
        rx_idle_pct  = 0;
      end
    endcase
  endtask

  // offer one page, with random gaps first; valid stays high after the transfer
  task automatic send_page(input logic [ENTRY_W-1:0] entry, input logic read_ok,
                           input logic first_pg, last_pg,
                           input bit typed, input pfch_pkg::pfch_result_t want);
    pfch_pkg::pfch_result_t predicted;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.entry <= {$urandom, $urandom};
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.entry      <= entry;
    in_ch.read_ok    <= read_ok;
    in_ch.first_page <= first_pg;
    in_ch.last_page  <= last_pg;
    do @(posedge clk); while (!in_ch.ready);
    predicted = census_step(entry, read_ok, first_pg, last_pg);
    census_expected.push_back(typed ? want : predicted);
  endtask

  // stop offering and let every outstanding result come out
  task automatic drain_census();
    in_ch.valid <= 1'b0;
    while (census_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(sel) << CFG_SEL_B;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (sel == pfch_pkg::REG_WINDOW_LOW) win_lo = value[FRAME_W-1:0];
    else win_hi = value[FRAME_W-1:0];
  endtask

  // result side: check each transfer, then decide ready for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      census_got = {out_ch.frame_number, out_ch.pages_seen, out_ch.pages_present,
                    out_ch.pages_in_window, out_ch.first_frame, out_ch.largest_frame,
                    out_ch.frame_hash, out_ch.region_done, out_ch.visibility_code};
      if (census_expected.size() == 0) note_mismatch("unexpected result", '0, '0);
      else check_result(census_got, census_expected.pop_front());
    end
    if (hold_taken != hold_req) begin
      hold_left  = LONG_HOLD;
      hold_taken = hold_req;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] lo, hi;
    logic [8:0]         pad;
    int                 sent;
    int                 region_len;
    bit                 skip_first, skip_last;

    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.entry      <= '0;
    in_ch.read_ok    <= 1'b0;
    in_ch.first_page <= 1'b0;
    in_ch.last_page  <= 1'b0;
    win_lo           = '0;
    win_hi           = '0;
    void'(census_step('0, 1'b0, 1'b1, 1'b0));
    seen_cnt         = '0;
    set_idle(SRC_LIGHT_RX_HEAVY);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // after reset, window disabled
    add_checked_page(64'h0, 1'b1, 1'b1, 1'b1,
                     census_row('0, 1, 0, 0, '0, '0, '0, 1'b1, pfch_pkg::VIS_NONE));
    add_checked_page(PRESENT_MASK | HASH_W'(FRAME_MAX), 1'b1, 1'b1, 1'b0,
                     census_row(FRAME_MAX, 1, 1, 0, FRAME_MAX, FRAME_MAX,
                                HASH_W'(FRAME_MAX), 1'b0, pfch_pkg::VIS_FINE));
    // unreadable entry counts as absent
    add_checked_page('1, 1'b0, 1'b0, 1'b1,
                     census_row('0, 2, 1, 0, FRAME_MAX, FRAME_MAX,
                                HASH_W'(FRAME_MAX), 1'b1, pfch_pkg::VIS_FINE));
    // stats carry on past a last page; ignored bits set; present with frame 0
    add_page(64'hFF80_0000_0000_0001, 1'b1, 1'b0, 1'b0);
    add_page(64'hFF80_0000_0000_0000, 1'b1, 1'b0, 1'b1);
    // present bit clear, warning given on every last page
    add_checked_page(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0,
                     census_row('0, 1, 0, 0, '0, '0, '0, 1'b0, pfch_pkg::VIS_FINE));
    add_checked_page(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1,
                     census_row('0, 2, 0, 0, '0, '0, '0, 1'b1, pfch_pkg::VIS_NONE));
    add_checked_page(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1,
                     census_row('0, 3, 0, 0, '0, '0, '0, 1'b1, pfch_pkg::VIS_NONE));
    // small window [5, 10), upper register bits are junk
    add_cfg(pfch_pkg::REG_WINDOW_LOW, 64'hFF80_0000_0000_0005);
    add_cfg(pfch_pkg::REG_WINDOW_HIGH, 64'hFF80_0000_0000_000A);
    add_page(PRESENT_MASK | 64'd4, 1'b1, 1'b1, 1'b0);
    add_page(PRESENT_MASK | 64'd5, 1'b1, 1'b0, 1'b0);
    add_page(PRESENT_MASK | 64'd7, 1'b0, 1'b0, 1'b0);
    add_page(PRESENT_MASK | 64'd9, 1'b1, 1'b0, 1'b0);
    add_page(PRESENT_MASK | 64'd10, 1'b1, 1'b0, 1'b1);
    // widest window
    add_cfg(pfch_pkg::REG_WINDOW_LOW, 64'h0);
    add_cfg(pfch_pkg::REG_WINDOW_HIGH, HASH_W'(FRAME_MAX));
    add_page(PRESENT_MASK | 64'd1, 1'b1, 1'b1, 1'b0);
    add_page(PRESENT_MASK | HASH_W'(FRAME_MAX), 1'b1, 1'b0, 1'b0);
    add_page(PRESENT_MASK | HASH_W'(FRAME_MAX - 1'b1), 1'b1, 1'b0, 1'b1);
    // window at the top, empty
    add_cfg(pfch_pkg::REG_WINDOW_LOW, '1);
    add_cfg(pfch_pkg::REG_WINDOW_HIGH, '1);
    add_page(PRESENT_MASK | HASH_W'(FRAME_MAX), 1'b1, 1'b1, 1'b1);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        drain_census();
        cfg_write(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_page(directed_rows[i].entry, directed_rows[i].read_ok, directed_rows[i].first_pg,
                  directed_rows[i].last_pg, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random regions, one window setting per phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_census();
      set_idle(idle_mode_t'(phase / 2));
      case (phase)
        0: begin
          lo = FRAME_W'($urandom_range(1, 1000));
          hi = lo + FRAME_W'($urandom_range(1, 1000));
        end
        1: begin
          lo = '0;
          hi = FRAME_MAX;
        end
        2: begin
          lo = FRAME_MAX;
          hi = FRAME_MAX;
        end
        3: begin
          lo = FRAME_W'({$urandom, $urandom});
          hi = FRAME_W'({$urandom, $urandom});
        end
        4: begin
          lo = FRAME_W'({$urandom, $urandom});
          hi = '0;
        end
        default: begin
          lo = FRAME_W'({$urandom, $urandom});
          hi = lo + FRAME_W'({$urandom_range(255), $urandom});
        end
      endcase
      pad = 9'($urandom);
      cfg_write(pfch_pkg::REG_WINDOW_LOW, {pad, lo});
      pad = 9'($urandom);
      cfg_write(pfch_pkg::REG_WINDOW_HIGH, {pad, hi});
      // long receiver hold-off while pages keep coming
      if (phase == 0 || phase == 4) hold_req++;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          send_page({$urandom, $urandom}, 1'($urandom_range(1)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), 1'b0, '0);
          sent++;
        end else begin
          region_len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
          skip_first = ($urandom_range(19) == 0);
          skip_last  = ($urandom_range(19) == 0);
          for (int i = 0; i < region_len; i++) begin
            send_page(pick_entry(), ($urandom_range(19) != 0), (i == 0 && !skip_first),
                      (i == region_len - 1 && !skip_last), 1'b0, '0);
            sent++;
          end
        end
      end
    end

    drain_census();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
